[rtl/crlf_command_line_framer_core_macros.svh]
// Assertion macros shared by the CR LF command line framer.
// Used by the top level only; no other dependencies.
`ifndef CRLF_COMMAND_LINE_FRAMER_CORE_MACROS_SVH
`define CRLF_COMMAND_LINE_FRAMER_CORE_MACROS_SVH

// Checks a consequence in the same cycle as its cause.
`define CRLF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks a consequence in the cycle after its cause.
`define CRLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/crlf_pkg.sv]
// Shared constants for the CR LF command line framer.
// No dependencies.
package crlf_pkg;

  localparam int LINE_DEPTH_DEF  = 64;
  localparam int MAX_COMMAND_DEF = 64;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_STOP = 8'h7F;

endpackage

[rtl/crlf_command_line_framer_core.sv]
// CR LF command line framer. One received byte or idle event is taken per cycle unless
// held off. Printable bytes, CR and LF build a line; when a chunk closes with the line
// ending in CR LF, the command of n bytes (the CR LF replaced by a final zero, marked by
// tlast) leaves one byte per cycle unless the output stalls. While a command waits in the
// queue or is being read out of the line store, the input is held off, since the store has
// a single write port shared with the next line. The store needs no clearing after reset.
// Depends on crlf_pkg, crlf_front, crlf_cmd_fifo, crlf_back and the macros header.
`include "crlf_command_line_framer_core_macros.svh"

module crlf_command_line_framer_core #(
  parameter int LINE_DEPTH  = crlf_pkg::LINE_DEPTH_DEF,
  parameter int MAX_COMMAND = crlf_pkg::MAX_COMMAND_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_byte
  input  logic       s_axis_tlast,   // chunk_end
  input  logic       s_axis_tuser,   // byte_present
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // cmd_byte
  output logic       m_axis_tlast    // cmd_last
);
  import crlf_pkg::*;

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int AW = $clog2(LINE_DEPTH);

  logic          wr_en, cmd_push, q_empty, pop, active, busy;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [CW-1:0] cmd_len, q_data;

  assign busy = !q_empty || active;

  crlf_front #(
    .LINE_DEPTH (LINE_DEPTH),
    .MAX_COMMAND(MAX_COMMAND)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cmd_push     (cmd_push),
    .cmd_len      (cmd_len)
  );

  crlf_cmd_fifo #(
    .W(CW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_data(cmd_len),
    .pop      (pop),
    .pop_data (q_data),
    .empty    (q_empty)
  );

  crlf_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .pop          (pop),
    .active       (active),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  `CRLF_ASSERT_NOW(a_last_is_zero, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata == CHAR_NUL, "command does not end in a zero byte")
  `CRLF_ASSERT_NOW(a_no_write_during_read, clk, rst, wr_en, !active && q_empty, "line store written while a command is read out")
  `CRLF_ASSERT_NEXT(a_push_holds_input, clk, rst, cmd_push, !s_axis_tready, "input not held after a command was queued")

endmodule

[rtl/crlf_front.sv]
// Front end: accepts bytes, filters them, tracks line and chunk counts.
// Writes kept bytes to the line store and queues finished commands; uses crlf_pkg.
module crlf_front #(
  parameter int LINE_DEPTH  = crlf_pkg::LINE_DEPTH_DEF,
  parameter int MAX_COMMAND = crlf_pkg::MAX_COMMAND_DEF,
  localparam int CW = $clog2(LINE_DEPTH + 1),
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tuser,
  input  logic          busy,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          cmd_push,
  output logic [CW-1:0] cmd_len
);
  import crlf_pkg::*;

  localparam logic [CW:0] DEPTH_W = (CW + 1)'(LINE_DEPTH);
  localparam bit MAX_BIG = MAX_COMMAND >= LINE_DEPTH;

  function automatic logic keep_byte(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF) || ((b >= PRINT_LO) && (b < PRINT_STOP));
  endfunction

  logic [CW-1:0] line_len, raw, kept;
  logic [7:0]    line_t0, line_t1, ch_t0, ch_t1;

  logic          acc, keep, close, fits, crlf, cmd_fits;
  logic [CW-1:0] raw_next, kept_next, newlen;
  logic [CW:0]   idx, raw_sum, joined;
  logic [7:0]    ch_t0_next, ch_t1_next, tail0, tail1;

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    keep       = s_axis_tuser && keep_byte(s_axis_tdata);
    raw_next   = raw + CW'(s_axis_tuser);
    kept_next  = kept + CW'(keep);
    ch_t0_next = keep ? ch_t1 : ch_t0;
    ch_t1_next = keep ? s_axis_tdata : ch_t1;
    idx        = {1'b0, line_len} + {1'b0, kept};
    close      = s_axis_tlast || (raw_next >= CW'(LINE_DEPTH));
    raw_sum    = {1'b0, raw_next} + {1'b0, line_len};
    fits       = raw_sum <= DEPTH_W;
    joined     = {1'b0, line_len} + {1'b0, kept_next};
    newlen     = fits ? joined[CW-1:0] : '0;
    if (kept_next >= CW'(2)) begin
      tail0 = ch_t0_next;
      tail1 = ch_t1_next;
    end else if (kept_next == CW'(1)) begin
      tail0 = line_t1;
      tail1 = ch_t1_next;
    end else begin
      tail0 = line_t0;
      tail1 = line_t1;
    end
    crlf     = (newlen >= CW'(2)) && (tail0 == CHAR_CR) && (tail1 == CHAR_LF);
    cmd_len  = newlen - CW'(1);
    cmd_fits = MAX_BIG || (cmd_len <= CW'(MAX_COMMAND));
  end

  assign wr_en    = acc && keep && (idx < DEPTH_W);
  assign wr_addr  = idx[AW-1:0];
  assign wr_data  = s_axis_tdata;
  assign cmd_push = acc && close && crlf && cmd_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len <= '0;
      raw      <= '0;
      kept     <= '0;
    end else if (acc) begin
      if (close) begin
        raw      <= '0;
        kept     <= '0;
        line_len <= crlf ? '0 : newlen;
      end else begin
        raw  <= raw_next;
        kept <= kept_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (close) begin
        line_t0 <= tail0;
        line_t1 <= tail1;
      end
      ch_t0 <= ch_t0_next;
      ch_t1 <= ch_t1_next;
    end
  end

endmodule

[rtl/crlf_cmd_fifo.sv]
// Short queue of command lengths between front end and back end.
// Depth comes from crlf_pkg.
module crlf_cmd_fifo #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import crlf_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);

  logic [W-1:0] slots [CMDQ_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign empty    = count == '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

endmodule

[rtl/crlf_back.sv]
// Back end: holds the line store and streams a queued command out of it.
// Takes command lengths from crlf_cmd_fifo; uses crlf_pkg.
module crlf_back #(
  parameter int LINE_DEPTH = crlf_pkg::LINE_DEPTH_DEF,
  localparam int CW = $clog2(LINE_DEPTH + 1),
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          q_empty,
  input  logic [CW-1:0] q_data,
  output logic          pop,
  output logic          active,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tlast
);
  import crlf_pkg::*;

  logic [7:0] mem [LINE_DEPTH];
  logic [CW-1:0] len, ptr;
  logic load, is_end;

  assign pop    = !active && !q_empty;
  assign load   = active && (!m_axis_tvalid || m_axis_tready);
  assign is_end = ptr == (len - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= is_end ? CHAR_NUL : mem[ptr[AW-1:0]];
      m_axis_tlast <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      len           <= '0;
      ptr           <= '0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        len    <= q_data;
        ptr    <= '0;
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
        ptr           <= ptr + CW'(1);
        if (is_end) begin
          active <= 1'b0;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
